@@ hw/rtl/pcthr_pkg.sv @@
// Shared types, register indexes and defaults for the per-client connection throttle.
package pcthr_pkg;

	localparam int MAX_ENTRIES_DEF   = 256;
	localparam int HISTORY_DEPTH_DEF = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BURST_COUNT      = 3'd0,
		CFG_MIN_WINDOW       = 3'd1,
		CFG_INFRACTION_LIMIT = 3'd2,
		CFG_BAN_SECONDS      = 3'd3,
		CFG_INFRACTION_EXP   = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		VERDICT_NEW        = 3'd0,
		VERDICT_KNOWN      = 3'd1,
		VERDICT_BANNED     = 3'd2,
		VERDICT_THROTTLED  = 3'd3,
		VERDICT_THR_BANNED = 3'd4,
		VERDICT_FULL       = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [31:0] peer_addr;
		logic [31:0] now_sec;
	} req_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic [7:0] infraction_count;
		logic [4:0] history_count;
	} res_t;

	typedef struct packed {
		logic [4:0]  burst_count;
		logic [15:0] min_window_sec;
		logic [7:0]  infraction_limit;
		logic [15:0] ban_seconds;
		logic [15:0] infraction_expiry_sec;
	} cfg_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic        sub;
	} alu_op_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        carry;
		logic        zero;
	} alu_res_t;

endpackage

@@ hw/rtl/per_client_connection_throttle_unit.sv @@
// Top level: client table, history ring memory and the sequencer around the shared ALU.
//
//  channel   ports                         handshake
//  request   start, busy, req              taken when start && !busy
//  result    done, res                     one-cycle strobe, cannot be held off
//  config    cfg_we, cfg_idx, cfg_wdata    written on any edge with cfg_we
//
// Sequence: a transaction searches the table one entry per cycle through the shared
// ALU (a miss ends with the new-entry write), then updates the matched entry with the
// same ALU.
// busy stays high from acceptance until the entry write-back or the miss step; done pulses once.
// Reset clears the state, the client count and the done strobe; table memories need no clearing.
// The receiver cannot stall; results are never held.
module per_client_connection_throttle_unit #(
	parameter int MAX_ENTRIES   = pcthr_pkg::MAX_ENTRIES_DEF,
	parameter int HISTORY_DEPTH = pcthr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  pcthr_pkg::req_t                  req,
	output logic                             done,
	output pcthr_pkg::res_t                  res,
	input  logic                             cfg_we,
	input  logic [pcthr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pcthr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int LW  = $clog2(HISTORY_DEPTH + 1);
	localparam int HW  = $clog2(HISTORY_DEPTH);
	localparam int TSW = $clog2(MAX_ENTRIES * HISTORY_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SRCH, ST_MISS, ST_LOAD, ST_LOAD2, ST_BANCHK, ST_REC,
		ST_TSRD, ST_DIFF, ST_WIN, ST_EXP1, ST_EXP2, ST_INC, ST_BANEND, ST_WB
	} state_t;

	state_t state_q;

	pcthr_pkg::cfg_t     cfg;
	pcthr_pkg::alu_op_t  alu_op;
	pcthr_pkg::alu_res_t alu_res;

	pcthr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pcthr_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	// table memories
	logic [31:0]  addr_mem  [MAX_ENTRIES];
	logic [LW-1:0] len_mem  [MAX_ENTRIES];
	logic [HW-1:0] head_mem [MAX_ENTRIES];
	logic [7:0]   inf_mem   [MAX_ENTRIES];
	logic [31:0]  bu_mem    [MAX_ENTRIES];
	logic [31:0]  first_mem [MAX_ENTRIES];
	logic [31:0]  ts_mem    [MAX_ENTRIES * HISTORY_DEPTH];

	// transaction and working registers
	pcthr_pkg::req_t req_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [EAW-1:0]  cmp_idx_q;
	logic            pend_q;
	logic [EAW-1:0]  e_q;
	logic [31:0]     addr_rd_q;
	logic [LW-1:0]   len_rd_q;
	logic [HW-1:0]   head_rd_q;
	logic [7:0]      inf_rd_q;
	logic [31:0]     bu_rd_q;
	logic [31:0]     first_rd_q;
	logic [31:0]     ts_rd_q;
	logic [LW-1:0]   len_q;
	logic [HW-1:0]   head_q;
	logic [7:0]      inf_q;
	logic [31:0]     bu_q;
	logic [31:0]     first_q;
	logic [31:0]     diff_q;
	logic            done_q;
	pcthr_pkg::res_t res_q;

	// burst length held to the legal range
	logic [LW-1:0] burst_eff;
	always_comb begin
		if (cfg.burst_count < 5'd2)
			burst_eff = LW'(2);
		else if (int'(cfg.burst_count) > HISTORY_DEPTH)
			burst_eff = LW'(HISTORY_DEPTH);
		else
			burst_eff = LW'(cfg.burst_count);
	end

	// logical history slot to ring position: one compare and subtract
	function automatic logic [HW-1:0] ring_pos(input logic [HW-1:0] head,
			input logic [LW-1:0] off);
		logic [LW:0] s;
		s = (LW+1)'(head) + (LW+1)'(off);
		if (s >= (LW+1)'(HISTORY_DEPTH))
			s = s - (LW+1)'(HISTORY_DEPTH);
		return s[HW-1:0];
	endfunction

	logic [HW-1:0]  wr_pos;
	logic [HW-1:0]  old_pos;
	logic [TSW-1:0] ts_wr_addr;
	logic [TSW-1:0] ts_rd_addr;
	logic [TSW-1:0] ts_new_addr;
	logic [8:0]     inf_inc;

	assign wr_pos      = ring_pos(head_q, len_q);
	assign old_pos     = ring_pos(head_q, len_q - burst_eff);
	assign ts_wr_addr  = TSW'(e_q) * TSW'(HISTORY_DEPTH) + TSW'(wr_pos);
	assign ts_rd_addr  = TSW'(e_q) * TSW'(HISTORY_DEPTH) + TSW'(old_pos);
	assign ts_new_addr = TSW'(count_q[EAW-1:0]) * TSW'(HISTORY_DEPTH);
	assign inf_inc     = {1'b0, inf_q} + 9'd1;

	// route operands to the shared ALU by step
	always_comb begin
		alu_op = '{a: req_q.now_sec, b: 32'd0, sub: 1'b1};
		case (state_q)
			ST_SRCH:   alu_op = '{a: req_q.peer_addr, b: addr_rd_q, sub: 1'b1};
			ST_BANCHK: alu_op = '{a: req_q.now_sec, b: bu_q, sub: 1'b1};
			ST_DIFF:   alu_op = '{a: req_q.now_sec, b: ts_rd_q, sub: 1'b1};
			ST_WIN:    alu_op = '{a: diff_q, b: {16'd0, cfg.min_window_sec}, sub: 1'b1};
			ST_EXP1:   alu_op = '{a: req_q.now_sec, b: first_q, sub: 1'b1};
			ST_EXP2:   alu_op = '{a: {16'd0, cfg.infraction_expiry_sec}, b: diff_q,
					sub: 1'b1};
			ST_BANEND: alu_op = '{a: req_q.now_sec, b: {16'd0, cfg.ban_seconds}, sub: 1'b0};
			default:   alu_op = '{a: req_q.now_sec, b: 32'd0, sub: 1'b1};
		endcase
	end

	// memory reads (registered) and writes
	always_ff @(posedge clk) begin
		addr_rd_q  <= addr_mem[idx_q[EAW-1:0]];
		len_rd_q   <= len_mem[e_q];
		head_rd_q  <= head_mem[e_q];
		inf_rd_q   <= inf_mem[e_q];
		bu_rd_q    <= bu_mem[e_q];
		first_rd_q <= first_mem[e_q];
		ts_rd_q    <= ts_mem[ts_rd_addr];
		if (state_q == ST_MISS && count_q != CW'(MAX_ENTRIES)) begin
			addr_mem[count_q[EAW-1:0]]  <= req_q.peer_addr;
			len_mem[count_q[EAW-1:0]]   <= LW'(1);
			head_mem[count_q[EAW-1:0]]  <= '0;
			inf_mem[count_q[EAW-1:0]]   <= 8'd0;
			bu_mem[count_q[EAW-1:0]]    <= 32'd0;
			first_mem[count_q[EAW-1:0]] <= 32'd0;
			ts_mem[ts_new_addr]         <= req_q.now_sec;
		end
		if (state_q == ST_REC)
			ts_mem[ts_wr_addr] <= req_q.now_sec;
		if (state_q == ST_WB) begin
			len_mem[e_q]   <= len_q;
			head_mem[e_q]  <= head_q;
			inf_mem[e_q]   <= inf_q;
			bu_mem[e_q]    <= bu_q;
			first_mem[e_q] <= first_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req;
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					// compare last fetched address, fetch the next one
					if (pend_q && alu_res.zero) begin
						e_q     <= cmp_idx_q;
						state_q <= ST_LOAD;
					end else if (idx_q == count_q) begin
						state_q <= ST_MISS;
					end else begin
						pend_q    <= 1'b1;
						cmp_idx_q <= idx_q[EAW-1:0];
						idx_q     <= idx_q + CW'(1);
					end
				end
				ST_MISS: begin
					done_q <= 1'b1;
					if (count_q == CW'(MAX_ENTRIES)) begin
						res_q <= '{verdict: pcthr_pkg::VERDICT_FULL,
							infraction_count: 8'd0, history_count: 5'd0};
					end else begin
						count_q <= count_q + CW'(1);
						res_q <= '{verdict: pcthr_pkg::VERDICT_NEW,
							infraction_count: 8'd0, history_count: 5'd1};
					end
					state_q <= ST_IDLE;
				end
				ST_LOAD: state_q <= ST_LOAD2;
				ST_LOAD2: begin
					inf_q   <= inf_rd_q;
					bu_q    <= bu_rd_q;
					first_q <= first_rd_q;
					// drop the oldest timestamp at a full history
					if (int'(len_rd_q) >= HISTORY_DEPTH) begin
						len_q  <= LW'(HISTORY_DEPTH - 1);
						head_q <= ring_pos(head_rd_q, LW'(1));
					end else begin
						len_q  <= len_rd_q;
						head_q <= head_rd_q;
					end
					state_q <= ST_BANCHK;
				end
				ST_BANCHK: begin
					if (!alu_res.carry) begin
						done_q  <= 1'b1;
						res_q   <= '{verdict: pcthr_pkg::VERDICT_BANNED,
							infraction_count: inf_q, history_count: 5'(len_q)};
						state_q <= ST_WB;
					end else begin
						state_q <= ST_REC;
					end
				end
				ST_REC: begin
					len_q <= len_q + LW'(1);
					if (len_q + LW'(1) >= burst_eff) begin
						state_q <= ST_TSRD;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{verdict: pcthr_pkg::VERDICT_KNOWN,
							infraction_count: inf_q, history_count: 5'(len_q + LW'(1))};
						state_q <= ST_WB;
					end
				end
				ST_TSRD: state_q <= ST_DIFF;
				ST_DIFF: begin
					diff_q <= alu_res.sum;
					if (alu_res.carry) begin
						state_q <= ST_WIN;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{verdict: pcthr_pkg::VERDICT_KNOWN,
							infraction_count: inf_q, history_count: 5'(len_q)};
						state_q <= ST_WB;
					end
				end
				ST_WIN: begin
					if (!alu_res.carry) begin
						state_q <= (inf_q == 8'd0) ? ST_INC : ST_EXP1;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{verdict: pcthr_pkg::VERDICT_KNOWN,
							infraction_count: inf_q, history_count: 5'(len_q)};
						state_q <= ST_WB;
					end
				end
				ST_EXP1: begin
					// time before the first infraction never expires the count
					diff_q  <= alu_res.sum;
					state_q <= alu_res.carry ? ST_EXP2 : ST_INC;
				end
				ST_EXP2: begin
					if (!alu_res.carry)
						inf_q <= 8'd0;
					state_q <= ST_INC;
				end
				ST_INC: begin
					if (inf_q == 8'd0)
						first_q <= req_q.now_sec;
					if (inf_inc > {1'b0, cfg.infraction_limit}) begin
						state_q <= ST_BANEND;
					end else begin
						inf_q   <= inf_inc[7:0];
						done_q  <= 1'b1;
						res_q   <= '{verdict: pcthr_pkg::VERDICT_THROTTLED,
							infraction_count: inf_inc[7:0], history_count: 5'(len_q)};
						state_q <= ST_WB;
					end
				end
				ST_BANEND: begin
					bu_q    <= alu_res.carry ? 32'hFFFF_FFFF : alu_res.sum;
					inf_q   <= 8'd0;
					done_q  <= 1'b1;
					res_q   <= '{verdict: pcthr_pkg::VERDICT_THR_BANNED,
						infraction_count: 8'd0, history_count: 5'(len_q)};
					state_q <= ST_WB;
				end
				ST_WB: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

`ifndef NO_ASSERTIONS
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction not busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES)) else $error("client count beyond table size");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(done && state_q == ST_IDLE) |-> $past(state_q) == ST_MISS)
		else $error("result without entry write-back");
`endif
endmodule

@@ hw/rtl/pcthr_alu.sv @@
// Shared 32-bit add/subtract unit with carry and zero flags.
module pcthr_alu (
	input  pcthr_pkg::alu_op_t  op,
	output pcthr_pkg::alu_res_t res
);
	logic [32:0] full;

	// carry set on a subtract means no borrow (a >= b)
	assign full      = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + {32'd0, op.sub};
	assign res.sum   = full[31:0];
	assign res.carry = full[32];
	assign res.zero  = (full[31:0] == 32'd0);
endmodule

@@ hw/rtl/pcthr_cfg.sv @@
// Configuration register file of the throttle.
module pcthr_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcthr_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [pcthr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output pcthr_pkg::cfg_t                     cfg
);
	pcthr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_count           <= 5'd10;
			cfg_q.min_window_sec        <= 16'd3;
			cfg_q.infraction_limit      <= 8'd25;
			cfg_q.ban_seconds           <= 16'd180;
			cfg_q.infraction_expiry_sec <= 16'd360;
		end else if (cfg_we) begin
			case (pcthr_pkg::cfg_idx_t'(cfg_idx))
				pcthr_pkg::CFG_BURST_COUNT:      cfg_q.burst_count <= cfg_wdata[4:0];
				pcthr_pkg::CFG_MIN_WINDOW:       cfg_q.min_window_sec <= cfg_wdata;
				pcthr_pkg::CFG_INFRACTION_LIMIT: cfg_q.infraction_limit <= cfg_wdata[7:0];
				pcthr_pkg::CFG_BAN_SECONDS:      cfg_q.ban_seconds <= cfg_wdata;
				pcthr_pkg::CFG_INFRACTION_EXP:   cfg_q.infraction_expiry_sec <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
